>>> hw/rtl/kswe_pkg.sv
package kswe_pkg;

  localparam int WORD_LEN = 4;
  localparam int NUM_WORDS = 60;
  localparam int WINDOW = NUM_WORDS + WORD_LEN;
  localparam int KEY_W = 8 * WORD_LEN;
  localparam int COUNT_W = $clog2(NUM_WORDS + 1);
  localparam int POS_W = $clog2(WINDOW);
  localparam int ENT_W = 20;
  localparam int REP_W = 6;
  localparam int REP_MAX = 63;
  localparam int FRAC_BITS = 30;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [REP_W-1:0] FIRST_REP =
    REP_W'((WINDOW / 2 + 1 > REP_MAX) ? REP_MAX : WINDOW / 2 + 1);
  localparam logic [REP_W-1:0] LAST_REP =
    REP_W'((WINDOW - WINDOW / 2 - 1 > REP_MAX) ? REP_MAX : WINDOW - WINDOW / 2 - 1);
  localparam logic [REP_W-1:0] SLIDE_REP = REP_W'(1);
  localparam logic [REP_W-1:0] SHORT_REP = '0;

  typedef enum logic [2:0] {
    OP_FILL,
    OP_FIRST,
    OP_SLIDE,
    OP_FINAL,
    OP_SHORT
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic             add_en;
    logic             rem_en;
    logic [KEY_W-1:0] add_key;
    logic [KEY_W-1:0] rem_key;
  } op_t;

  typedef logic [NUM_WORDS:0][ENT_W-1:0] term_rom_t;

  // log2 in q.30, integer part from the leading one, fraction by repeated squaring
  function automatic longint unsigned log2_q30(longint unsigned x);
    longint unsigned m;
    longint unsigned r;
    int unsigned     n;
    n = 0;
    for (int s = 0; s < 62; s++) begin
      if ((x >> (s + 1)) != 0) n = s + 1;
    end
    m = (x << FRAC_BITS) >> n;
    r = 64'(n) << FRAC_BITS;
    for (int b = FRAC_BITS - 1; b >= 0; b--) begin
      m = (m * m) >> FRAC_BITS;
      if (m >= (64'd2 << FRAC_BITS)) begin
        m = m >> 1;
        r = r | (64'd1 << b);
      end
    end
    if (x == 0) r = 0;
    return r;
  endfunction

  function automatic longint unsigned alphabet_span();
    longint unsigned d;
    d = 1;
    for (int j = 0; j < WORD_LEN; j++) d = d * 4;
    if (d > NUM_WORDS) d = NUM_WORDS;
    return d;
  endfunction

  localparam longint unsigned LogN = log2_q30(NUM_WORDS);
  localparam longint unsigned LogD = log2_q30(alphabet_span());
  localparam longint unsigned TermDen = 64'(NUM_WORDS) * LogD;

  function automatic term_rom_t build_term_rom();
    term_rom_t       t;
    longint unsigned lc;
    longint unsigned diff;
    longint unsigned num;
    longint unsigned val;
    t = '0;
    for (int c = 1; c <= NUM_WORDS; c++) begin
      lc = log2_q30(64'(c));
      diff = (LogN > lc) ? LogN - lc : 64'd0;
      num = (64'(c) * diff) << 16;
      val = (TermDen != 0) ? (num + TermDen / 2) / TermDen : 64'd0;
      t[c] = ENT_W'(val);
    end
    return t;
  endfunction

  localparam term_rom_t TERM_ROM = build_term_rom();

endpackage

>>> hw/rtl/kswe_in_if.sv
interface kswe_in_if import kswe_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_sequence;

  modport source (output valid, output symbol, output end_of_sequence, input ready);
  modport sink (input valid, input symbol, input end_of_sequence, output ready);
endinterface

>>> hw/rtl/kswe_out_if.sv
interface kswe_out_if import kswe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ENT_W-1:0] entropy;
  logic [REP_W-1:0] repeat_count;
  logic             final_result;
  logic             too_short;

  modport source (output valid, output entropy, output repeat_count,
                  output final_result, output too_short, input ready);
  modport sink (input valid, input entropy, input repeat_count,
                input final_result, input too_short, output ready);
endinterface

>>> hw/rtl/kswe_front.sv
module kswe_front import kswe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  kswe_in_if.sink   bytes,
  output op_t       op,
  output logic      op_push,
  input  logic      op_full
);

  logic [7:0]       hist [WINDOW];
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             accept;

  assign bytes.ready = !op_full;
  assign accept = bytes.valid && bytes.ready;
  assign op_push = accept;

  always_comb begin
    op.add_key = '0;
    op.rem_key = '0;
    for (int j = 0; j < WORD_LEN; j++) begin
      op.add_key[8*j +: 8] = (j == 0) ? bytes.symbol : hist[(j == 0) ? 0 : j - 1];
      op.rem_key[8*j +: 8] = hist[WINDOW - WORD_LEN + j - 1];
    end
    op.add_en = 1'b0;
    op.rem_en = 1'b0;
    op.kind = OP_FILL;
    pos_next = pos;
    if (pos < POS_W'(WINDOW - 1)) begin
      if (bytes.end_of_sequence) begin
        op.kind = OP_SHORT;
        pos_next = '0;
      end else begin
        op.add_en = (pos >= POS_W'(WORD_LEN - 1));
        op.kind = (pos == POS_W'(WINDOW - 2)) ? OP_FIRST : OP_FILL;
        pos_next = pos + 1'b1;
      end
    end else if (bytes.end_of_sequence) begin
      op.kind = OP_FINAL;
      pos_next = '0;
    end else begin
      op.kind = OP_SLIDE;
      op.add_en = 1'b1;
      op.rem_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist[0] <= bytes.symbol;
      for (int a = 1; a < WINDOW; a++) hist[a] <= hist[a-1];
    end
  end

endmodule

>>> hw/rtl/kswe_op_queue.sv
module kswe_op_queue import kswe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  op_t  push_op,
  input  logic push,
  output logic full,
  output op_t  head,
  output logic head_valid,
  input  logic pop
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_op;
  end

endmodule

>>> hw/rtl/kswe_back.sv
module kswe_back import kswe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  op_t        op,
  input  logic       op_valid,
  output logic       op_pop,
  kswe_out_if.source results
);

  logic [KEY_W-1:0]   keys   [NUM_WORDS];
  logic [COUNT_W-1:0] counts [NUM_WORDS];
  logic [COUNT_W-1:0] cnt_r  [NUM_WORDS];
  logic [COUNT_W-1:0] cnt_n  [NUM_WORDS];
  logic [NUM_WORDS-1:0] rem_hit;
  logic [NUM_WORDS-1:0] add_hit;
  logic [NUM_WORDS-1:0] free_vec;
  logic [NUM_WORDS-1:0] first_free;
  logic [NUM_WORDS-1:0] alloc;
  logic [COUNT_W-1:0] rc;
  logic [COUNT_W-1:0] rcn;
  logic [COUNT_W-1:0] ac;
  logic [COUNT_W-1:0] acn;
  logic [ENT_W-1:0]   sum;
  logic [ENT_W-1:0]   sum_next;
  logic               same;
  logic               rem_do;
  logic               add_do;
  logic               emits;
  logic               clear;
  logic               ac_inc;

  assign same = op.rem_en && (op.add_key == op.rem_key);
  assign rem_do = op.rem_en && !same;
  assign add_do = op.add_en && !same;
  assign emits = (op.kind != OP_FILL);
  assign clear = (op.kind == OP_FINAL) || (op.kind == OP_SHORT);
  assign op_pop = op_valid && (!emits || !results.valid || results.ready);

  always_comb begin
    rc = '0;
    ac = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      rem_hit[i] = rem_do && (counts[i] != '0) && (keys[i] == op.rem_key);
      cnt_r[i] = counts[i] - COUNT_W'(rem_hit[i]);
      add_hit[i] = add_do && (cnt_r[i] != '0) && (keys[i] == op.add_key);
      free_vec[i] = (cnt_r[i] == '0);
      rc = rc | (rem_hit[i] ? counts[i] : '0);
      ac = ac | (add_hit[i] ? cnt_r[i] : '0);
    end
    first_free = free_vec & (~free_vec + 1'b1);
    alloc = (add_do && (add_hit == '0)) ? first_free : '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (add_hit[i] && (cnt_r[i] != COUNT_W'(NUM_WORDS))) cnt_n[i] = cnt_r[i] + 1'b1;
      else if (alloc[i]) cnt_n[i] = COUNT_W'(1);
      else cnt_n[i] = cnt_r[i];
    end
    ac_inc = ((add_hit != '0) && (ac != COUNT_W'(NUM_WORDS))) || (alloc != '0);
    acn = ac_inc ? ac + 1'b1 : ac;
    rcn = (rem_hit != '0) ? rc - 1'b1 : rc;
    sum_next = sum - TERM_ROM[rc] + TERM_ROM[rcn] - TERM_ROM[ac] + TERM_ROM[acn];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      for (int i = 0; i < NUM_WORDS; i++) counts[i] <= '0;
    end else if (op_pop) begin
      if (clear) begin
        sum <= '0;
        for (int i = 0; i < NUM_WORDS; i++) counts[i] <= '0;
      end else begin
        sum <= sum_next;
        for (int i = 0; i < NUM_WORDS; i++) counts[i] <= cnt_n[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        if (alloc[i]) keys[i] <= op.add_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (op_pop && emits) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && emits) begin
      results.entropy <= (op.kind == OP_SHORT) ? '0 : sum_next;
      results.final_result <= clear;
      results.too_short <= (op.kind == OP_SHORT);
      case (op.kind)
        OP_FIRST: results.repeat_count <= FIRST_REP;
        OP_SLIDE: results.repeat_count <= SLIDE_REP;
        OP_FINAL: results.repeat_count <= LAST_REP;
        default:  results.repeat_count <= SHORT_REP;
      endcase
    end
  end

  a_rem_unique: assert property (@(posedge clk) disable iff (rst)
      op_valid |-> $onehot0(rem_hit))
    else $error("removed word matches more than one entry");
  a_add_unique: assert property (@(posedge clk) disable iff (rst)
      op_valid |-> $onehot0(add_hit | alloc))
    else $error("added word lands in more than one entry");
  a_slide_present: assert property (@(posedge clk) disable iff (rst)
      op_pop && (op.kind == OP_SLIDE) && !same |-> (rem_hit != '0))
    else $error("word leaving the window not found");
  a_clear_sum: assert property (@(posedge clk) disable iff (rst)
      op_pop && clear |=> (sum == '0) && (counts[0] == '0))
    else $error("state not cleared after final result");

endmodule

>>> hw/rtl/kmer_sliding_window_entropy_core.sv
// Sliding-window word entropy over a byte stream: one byte is taken per cycle while the queue
// has room and, once the first window is full, one result leaves per cycle while the output is
// ready, registered behind the queue. The front keeps the byte history and window position and
// classifies each byte; a four-deep request queue feeds the back, whose combinational match
// over all word entries and two table-driven count updates set the one-byte-per-cycle rate. A
// stalled output lets the queue absorb up to four more bytes before input ready drops.
module kmer_sliding_window_entropy_core import kswe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  kswe_in_if.sink    bytes,
  kswe_out_if.source results
);

  op_t  push_op;
  logic push;
  logic full;
  op_t  head;
  logic head_valid;
  logic pop;

  kswe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .op      (push_op),
    .op_push (push),
    .op_full (full)
  );

  kswe_op_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_op    (push_op),
    .push       (push),
    .full       (full),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  kswe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (head),
    .op_valid (head_valid),
    .op_pop   (pop),
    .results  (results)
  );

endmodule

>>> dv/tb_kmer_sliding_window_entropy_core.sv
`timescale 1ns / 100ps

module tb_kmer_sliding_window_entropy_core;
  import kswe_pkg::*;

  typedef struct {
    logic [ENT_W-1:0] entropy;
    logic [REP_W-1:0] repeat_count;
    logic             final_result;
    logic             too_short;
  } entropy_result_t;

  localparam int STALL_LIMIT = 5000;

  // content styles of a generated sequence
  localparam int unsigned STYLE_SAME = 0;
  localparam int unsigned STYLE_FOUR = 1;
  localparam int unsigned STYLE_ANY = 2;
  localparam int unsigned STYLE_PERIODIC = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kswe_in_if  bytes_if ();
  kswe_out_if results_if ();

  kmer_sliding_window_entropy_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  logic [ENT_W-1:0] term_table [0:NUM_WORDS];
  logic [7:0]       history [0:WINDOW-1];
  int unsigned      word_tally [logic [KEY_W-1:0]];
  logic [ENT_W-1:0] running_entropy;
  int unsigned      seq_pos;
  entropy_result_t  pending_results [$];
  int               error_count = 0;
  bit               quiet = 1'b0;
  int               idle_cycles = 0;

  function automatic longint unsigned fixed_log2(longint unsigned x);
    longint unsigned mant;
    longint unsigned acc;
    int unsigned     lead;
    lead = 0;
    if (x == 0) return 0;
    while (lead < 62 && (x >> (lead + 1)) != 0) lead++;
    mant = (x << FRAC_BITS) >> lead;
    acc = longint'(lead) << FRAC_BITS;
    for (int b = FRAC_BITS - 1; b >= 0; b--) begin
      mant = (mant * mant) >> FRAC_BITS;
      if (mant >= (64'd2 << FRAC_BITS)) begin
        mant = mant >> 1;
        acc = acc | (64'd1 << b);
      end
    end
    return acc;
  endfunction

  task automatic fill_term_table();
    longint unsigned span;
    longint unsigned log_n;
    longint unsigned den;
    longint unsigned log_c;
    longint unsigned num;
    span = 1;
    for (int j = 0; j < WORD_LEN; j++) span = span * 4;
    if (span > NUM_WORDS) span = NUM_WORDS;
    log_n = fixed_log2(NUM_WORDS);
    den = longint'(NUM_WORDS) * fixed_log2(span);
    term_table[0] = '0;
    for (int c = 1; c <= NUM_WORDS; c++) begin
      log_c = fixed_log2(c);
      num = (longint'(c) * ((log_n > log_c) ? log_n - log_c : 0)) << 16;
      term_table[c] = (den != 0) ? ENT_W'((num + den / 2) / den) : '0;
    end
  endtask

  function automatic void clear_window();
    for (int k = 0; k < WINDOW; k++) history[k] = '0;
    word_tally.delete();
    running_entropy = '0;
    seq_pos = 0;
  endfunction

  function automatic logic [KEY_W-1:0] word_from(int unsigned age);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int j = WORD_LEN - 1; j >= 0; j--) key = (key << 8) | history[age + j];
    return key;
  endfunction

  function automatic void set_tally(logic [KEY_W-1:0] key, int unsigned old_c,
                                    int unsigned new_c);
    running_entropy = running_entropy - term_table[old_c] + term_table[new_c];
    if (new_c == 0) word_tally.delete(key);
    else word_tally[key] = new_c;
  endfunction

  function automatic void add_kmer(logic [KEY_W-1:0] key);
    if (!word_tally.exists(key)) set_tally(key, 0, 1);
    else if (word_tally[key] < NUM_WORDS) set_tally(key, word_tally[key], word_tally[key] + 1);
  endfunction

  function automatic void drop_kmer(logic [KEY_W-1:0] key);
    if (word_tally.exists(key)) set_tally(key, word_tally[key], word_tally[key] - 1);
  endfunction

  function automatic void push_result(logic [ENT_W-1:0] ent, int unsigned rep,
                                      logic fin, logic shrt);
    entropy_result_t r;
    r.entropy = ent;
    r.repeat_count = REP_W'((rep > REP_MAX) ? REP_MAX : rep);
    r.final_result = fin;
    r.too_short = shrt;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_entropy(logic [7:0] sym, logic eos);
    int unsigned i;
    i = seq_pos;
    for (int k = WINDOW - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = sym;
    if (i < WINDOW - 1) begin
      if (i >= WORD_LEN - 1) add_kmer(word_from(0));
      if (eos) begin
        push_result('0, 0, 1'b1, 1'b1);
        clear_window();
        return;
      end
      seq_pos = i + 1;
      if (i == WINDOW - 2) push_result(running_entropy, WINDOW / 2 + 1, 1'b0, 1'b0);
      return;
    end
    if (eos) begin
      push_result(running_entropy, WINDOW - WINDOW / 2 - 1, 1'b1, 1'b0);
      clear_window();
      return;
    end
    drop_kmer(word_from(WINDOW - WORD_LEN));
    add_kmer(word_from(0));
    push_result(running_entropy, 1, 1'b0, 1'b0);
  endfunction

  task automatic send_byte(logic [7:0] sym, logic eos);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      bytes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.symbol <= sym;
    bytes_if.end_of_sequence <= eos;
    do @(posedge clk); while (!bytes_if.ready);
    predict_entropy(sym, eos);
  endtask

  task automatic send_sequence(int unsigned len, int unsigned style);
    logic [7:0] letters [4];
    logic [7:0] sym;
    int unsigned period;
    foreach (letters[k]) letters[k] = 8'($urandom);
    period = $urandom_range(1, 7);
    for (int unsigned n = 0; n < len; n++) begin
      case (style)
        STYLE_SAME: sym = letters[0];
        STYLE_FOUR: sym = letters[$urandom_range(0, 3)];
        STYLE_ANY: sym = 8'($urandom);
        default: sym = letters[(n % period) % 4];
      endcase
      send_byte(sym, n == len - 1);
    end
  endtask

  task automatic test_short_sequences();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_sequence(WORD_LEN, STYLE_ANY);
  endtask

  task automatic test_window_edges();
    send_sequence(WINDOW - 1, STYLE_FOUR);
    send_sequence(WINDOW, STYLE_SAME);
    send_sequence(WINDOW + 1, STYLE_ANY);
  endtask

  task automatic test_random_sequences(int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, WINDOW - 1);
      else len = $urandom_range(WINDOW, WINDOW + 60);
      send_sequence(len, $urandom_range(STYLE_SAME, STYLE_PERIODIC));
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (quiet) begin
      results_if.ready <= 1'b1;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      results_if.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      idle_cycles <= $urandom_range(0, 15);
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    entropy_result_t exp_r;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result entropy=%0d rep=%0d fin=%0d short=%0d", $time,
                 results_if.entropy, results_if.repeat_count, results_if.final_result,
                 results_if.too_short);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (results_if.entropy !== exp_r.entropy) begin
          $display("%0t: entropy expected %0d actual %0d", $time, exp_r.entropy,
                   results_if.entropy);
          error_count++;
        end
        if (results_if.repeat_count !== exp_r.repeat_count) begin
          $display("%0t: repeat_count expected %0d actual %0d", $time, exp_r.repeat_count,
                   results_if.repeat_count);
          error_count++;
        end
        if (results_if.final_result !== exp_r.final_result) begin
          $display("%0t: final_result expected %0d actual %0d", $time, exp_r.final_result,
                   results_if.final_result);
          error_count++;
        end
        if (results_if.too_short !== exp_r.too_short) begin
          $display("%0t: too_short expected %0d actual %0d", $time, exp_r.too_short,
                   results_if.too_short);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    int unsigned stuck;
    if ((bytes_if.valid && bytes_if.ready) || (results_if.valid && results_if.ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    bytes_if.valid = 1'b0;
    bytes_if.symbol = '0;
    bytes_if.end_of_sequence = 1'b0;
    fill_term_table();
    clear_window();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_sequences();
    test_window_edges();
    test_random_sequences(620);
    quiet = 1'b1;
    test_random_sequences(120);
    bytes_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> kmer_sliding_window_entropy_core.f
hw/rtl/kswe_pkg.sv
hw/rtl/kswe_in_if.sv
hw/rtl/kswe_out_if.sv
hw/rtl/kswe_front.sv
hw/rtl/kswe_op_queue.sv
hw/rtl/kswe_back.sv
hw/rtl/kmer_sliding_window_entropy_core.sv
dv/tb_kmer_sliding_window_entropy_core.sv
